// ===== design/bff_pkg.sv =====
// bff_pkg: shared types and constants for the bitmap find-first block.
// Depends on nothing; used by every file under design/.
`timescale 1ns / 1ps

package bff_pkg;

  // Fixed field widths and geometry
  localparam int unsigned INDEX_W    = 12;
  localparam int unsigned LIMIT_W    = 13;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned BYTES_W    = 10;
  localparam int unsigned INDEX_LIMIT = 4096;
  localparam logic [7:0]  BYTE_ONES  = 8'hFF;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_FIND  = 2'd2,
    FUNC_FILL  = 2'd3
  } func_t;

  // Input word
  typedef struct packed {
    logic [1:0]         func;
    logic [INDEX_W-1:0] bit_index;
    logic               bit_value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic               bit_out;
    logic [INDEX_W-1:0] found_index;
    logic               found;
    logic               range_error;
  } out_word_t;

endpackage

// ===== design/bff_match.sv =====
// bff_match: lowest set position of (word matches value) under a live mask.
// Depends on bff_pkg for the word width.
`timescale 1ns / 1ps

module bff_match (
  input  logic [bff_pkg::WORD_BITS-1:0] word,
  input  logic                          value,
  input  logic [bff_pkg::WORD_BITS-1:0] mask,
  output logic                          hit,
  output logic [5:0]                    pos
);

  logic [bff_pkg::WORD_BITS-1:0] match;
  logic [7:0]                    byte_hit;
  logic [2:0]                    byte_sel;
  logic [7:0]                    sel_byte;
  logic [2:0]                    bit_sel;

  // Bits equal to the sought value, live only
  assign match = (value ? word : ~word) & mask;

  // One flag per byte
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_hit[b] = |match[b*8 +: 8];
    end
  end

  // First byte with a hit
  always_comb begin
    byte_sel = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (byte_hit[b]) begin
        byte_sel = 3'(b);
      end
    end
  end

  assign sel_byte = match[{byte_sel, 3'b000} +: 8];

  // First bit inside that byte
  always_comb begin
    bit_sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (sel_byte[i]) begin
        bit_sel = 3'(i);
      end
    end
  end

  assign hit = |byte_hit;
  assign pos = {byte_sel, bit_sel};

endmodule

// ===== design/bitmap_find_first.sv =====
// bitmap_find_first: bitmap with bit write/read, find-first and fill.
// Depends on bff_pkg and bff_match.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  in      | in_valid in_ready in_data      | one operation word
//  out     | out_valid out_ready out_data   | one result word per operation
//  cfg     | cfg_we cfg_data                | bytes_in_use, no wait
//
// Write and read pass from accept to result through read, modify, result;
// a write or read with its index out of range goes straight to the result.
// Find and fill walk the live 64-bit words (up to 64 of them),
// one memory word per cycle through the single read port.
// Reset clears the per-word valid flags at once; no clearing pass is needed.
// A waiting result sits in the output register; a new word is accepted
// meanwhile, and only the final hand-off of the next result waits on it.
`timescale 1ns / 1ps

module bitmap_find_first #(
  parameter int unsigned MAX_BYTES = 512
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bff_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bff_pkg::out_word_t        out_data,
  input  logic                      cfg_we,
  input  logic [bff_pkg::BYTES_W-1:0] cfg_data
);

  // Only the first 4096 bits are reachable by a 12-bit index
  localparam int unsigned STORE_WORDS = (MAX_BYTES + 7) / 8;
  localparam int unsigned WORDS = (STORE_WORDS < 64) ? STORE_WORDS : 64;
  localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned WB = bff_pkg::WORD_BITS;
  localparam int unsigned LW = bff_pkg::LIMIT_W;
  localparam int unsigned BW = bff_pkg::BYTES_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ACCESS = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FILL   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [BW-1:0]       biu_r;
  logic [1:0]          func_r, func_nxt;
  logic [bff_pkg::INDEX_W-1:0] idx_r, idx_nxt;
  logic                val_r, val_nxt;
  logic [BW-1:0]       lb_r, lb_nxt;
  logic [LW-1:0]       limit_r, limit_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [AW:0]         words_r, words_nxt;
  bff_pkg::out_word_t  res_r, res_nxt;
  bff_pkg::out_word_t  out_data_r;
  logic                out_valid_r, out_valid_nxt;

  // Memory and per-word valid flags
  logic [WB-1:0]       mem [WORDS];
  logic [WORDS-1:0]    vld_r;
  logic [WB-1:0]       rd_data_r;
  logic                rd_vld_r;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [WB-1:0]       wr_data;

  // Live length from the register
  logic [BW-1:0]       lb_cur;
  logic [LW-1:0]       limit_cur;
  logic [7:0]          fill_words;
  logic [6:0]          find_words;
  logic [AW-1:0]       idx_addr;
  logic                in_range;
  logic                accept;

  // Current word and helpers
  logic [WB-1:0]       word;
  logic [AW:0]         cnt_inc;
  logic                last_word;
  logic [LW-1:0]       bit_base, bit_rem;
  logic [WB-1:0]       live_mask;
  logic [BW-1:0]       byte_base, byte_rem;
  logic [WB-1:0]       fill_mask;
  logic [WB-1:0]       access_word;
  logic                m_hit;
  logic [5:0]          m_pos;

  assign lb_cur = (32'(biu_r) > MAX_BYTES) ? BW'(MAX_BYTES) : biu_r;
  assign limit_cur = ({lb_cur, 3'b000} > LW'(bff_pkg::INDEX_LIMIT))
                     ? LW'(bff_pkg::INDEX_LIMIT) : {lb_cur, 3'b000};
  assign fill_words = 8'((11'(lb_cur) + 11'd7) >> 3);
  assign find_words = 7'((14'(limit_cur) + 14'd63) >> 6);
  assign idx_addr   = AW'(in_data.bit_index[11:6]);
  assign in_range   = 13'(in_data.bit_index) < limit_cur;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign word      = rd_vld_r ? rd_data_r : '0;
  assign cnt_inc   = {1'b0, cnt_r} + (AW+1)'(1);
  assign last_word = (cnt_inc == words_r);

  // Live bits of the word under scan
  assign bit_base = LW'(cnt_r) << 6;
  assign bit_rem  = limit_r - bit_base;
  assign live_mask = (bit_rem >= LW'(WB)) ? '1 : ~({WB{1'b1}} << bit_rem[5:0]);

  // Live bytes of the word under fill
  assign byte_base = BW'(cnt_r) << 3;
  assign byte_rem  = lb_r - byte_base;
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      fill_mask[b*8 +: 8] = (BW'(b) < byte_rem) ? bff_pkg::BYTE_ONES : 8'h00;
    end
  end

  // Single-bit update of the accessed word
  always_comb begin
    access_word = word;
    access_word[idx_r[5:0]] = val_r;
  end

  bff_match u_match (
    .word  (word),
    .value (val_r),
    .mask  (live_mask),
    .hit   (m_hit),
    .pos   (m_pos)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    lb_nxt        = lb_r;
    limit_nxt     = limit_r;
    cnt_nxt       = cnt_r;
    words_nxt     = words_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = 1'b0;
    rd_addr       = cnt_inc[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = cnt_r;
    wr_data       = access_word;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt  = in_data.func;
          idx_nxt   = in_data.bit_index;
          val_nxt   = in_data.bit_value;
          lb_nxt    = lb_cur;
          limit_nxt = limit_cur;
          cnt_nxt   = '0;
          res_nxt   = '0;
          rd_en     = 1'b1;
          rd_addr   = '0;
          case (in_data.func)
            bff_pkg::FUNC_WRITE, bff_pkg::FUNC_READ: begin
              rd_addr = idx_addr;
              if (in_range) begin
                state_nxt = S_ACCESS;
              end else begin
                res_nxt.range_error = 1'b1;
                state_nxt = S_DONE;
              end
            end
            bff_pkg::FUNC_FIND: begin
              words_nxt = (32'(find_words) > WORDS) ? (AW+1)'(WORDS)
                                                    : (AW+1)'(find_words);
              state_nxt = (find_words == 7'd0) ? S_DONE : S_SCAN;
            end
            default: begin
              words_nxt = (32'(fill_words) > WORDS) ? (AW+1)'(WORDS)
                                                    : (AW+1)'(fill_words);
              state_nxt = (fill_words == 8'd0) ? S_DONE : S_FILL;
            end
          endcase
        end
      end
      S_ACCESS: begin
        wr_addr = AW'(idx_r[11:6]);
        if (func_r == bff_pkg::FUNC_WRITE) begin
          wr_en = 1'b1;
        end else begin
          res_nxt.bit_out = word[idx_r[5:0]];
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        rd_en = !last_word;
        if (m_hit) begin
          res_nxt.found       = 1'b1;
          res_nxt.found_index = (bff_pkg::INDEX_W'(cnt_r) << 6)
                                | bff_pkg::INDEX_W'(m_pos);
          state_nxt = S_DONE;
        end else if (last_word) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_inc[AW-1:0];
        end
      end
      S_FILL: begin
        rd_en   = !last_word;
        wr_en   = 1'b1;
        wr_data = (word & ~fill_mask) | ({WB{val_r}} & fill_mask);
        if (last_word) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_inc[AW-1:0];
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      biu_r       <= BW'(512);
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        biu_r <= cfg_data;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    lb_r    <= lb_nxt;
    limit_r <= limit_nxt;
    cnt_r   <= cnt_nxt;
    words_r <= words_nxt;
    res_r   <= res_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_data_r <= res_r;
    end
  end

  // Bitmap memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/bff_checker.sv =====
// bff_checker: port-level checks of bitmap_find_first, bound to the top level.
// Depends on bff_pkg and bitmap_find_first.
`timescale 1ns / 1ps

module bff_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bff_pkg::out_word_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A find result carries no read bit and no range error
  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> !out_data.range_error && !out_data.bit_out)
    else $error("found result with read or error flags");

  // Not found means index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.found_index == '0)
    else $error("index without a find hit");

  // A range error reads no bit
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |-> !out_data.bit_out)
    else $error("bit returned with range error");

  // Reset empties the output and readies the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind bitmap_find_first bff_checker u_bff_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/tb_bitmap_find_first.sv =====
// tb_bitmap_find_first: self-checking bench for the bitmap find-first block.
// Depends on bff_pkg and bitmap_find_first; a directed table first, then random phases
// across live sizes and handshake stall patterns, scored by table values or a behavioral bitmap.
`timescale 1ns / 1ps

module tb_bitmap_find_first;
  import bff_pkg::*;

  localparam int unsigned TB_MAX_BYTES    = 512;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned WORDS_PER_PHASE = 170;
  localparam int unsigned SETTLE_CYCLES   = 80;       // > longest find/fill walk
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned MAX_REPORTS     = 10;

  // Idle patterns
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One directed stimulus row
  typedef struct {
    bit          set_cfg;
    logic [9:0]  cfg;
    in_word_t    word;
    bit          typed;
    out_word_t   want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [BYTES_W-1:0]   cfg_data  = '0;

  // Behavioral copy of the block
  bit [INDEX_LIMIT-1:0] bitmap_img;
  logic [BYTES_W-1:0]   live_cfg;

  out_word_t            pending_results[$];
  plan_row_t            plan[$];

  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  int unsigned          cycle_count   = 0;
  int unsigned          words_sent    = 0;
  int unsigned          results_seen  = 0;
  int unsigned          finds_hit     = 0;
  int unsigned          range_errs    = 0;
  int unsigned          mismatches    = 0;

  bitmap_find_first #(
    .MAX_BYTES (TB_MAX_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Live bit count under the current register, saturated to the array size
  function automatic int unsigned live_bit_count();
    int unsigned nbytes;
    nbytes = (32'(live_cfg) > TB_MAX_BYTES) ? TB_MAX_BYTES : 32'(live_cfg);
    return (nbytes * 8 > INDEX_LIMIT) ? INDEX_LIMIT : nbytes * 8;
  endfunction

  // Apply one operation to the bitmap copy and return the result it gives
  function automatic out_word_t bitmap_apply(in_word_t w);
    out_word_t   r;
    int unsigned nbits;
    int unsigned idx;
    int unsigned i;
    r     = '0;
    nbits = live_bit_count();
    idx   = 32'(w.bit_index);
    case (w.func)
      FUNC_WRITE: begin
        if (idx >= nbits) r.range_error = 1'b1;
        else bitmap_img[idx] = w.bit_value;
      end
      FUNC_READ: begin
        if (idx >= nbits) r.range_error = 1'b1;
        else r.bit_out = bitmap_img[idx];
      end
      FUNC_FIND: begin
        for (i = 0; i < nbits && !r.found; i++) begin
          if (bitmap_img[i] == w.bit_value) begin
            r.found       = 1'b1;
            r.found_index = 12'(i);
          end
        end
      end
      default: begin
        // fill touches live bytes only; live bits are exactly those bytes
        for (i = 0; i < nbits; i++) bitmap_img[i] = w.bit_value;
      end
    endcase
    return r;
  endfunction

  function automatic out_word_t result_word(logic bo, logic [INDEX_W-1:0] fi, logic fd,
                                            logic re);
    out_word_t r;
    r.bit_out     = bo;
    r.found_index = fi;
    r.found       = fd;
    r.range_error = re;
    return r;
  endfunction

  task automatic add_row(input bit set_cfg, input logic [9:0] cfg, input func_t f,
                         input logic [INDEX_W-1:0] idx, input logic v, input bit typed,
                         input out_word_t want);
    plan_row_t row;
    row.set_cfg        = set_cfg;
    row.cfg            = cfg;
    row.word.func      = f;
    row.word.bit_index = idx;
    row.word.bit_value = v;
    row.typed          = typed;
    row.want           = want;
    plan.push_back(row);
  endtask

  // Random word, biased toward low bits, the top of the live range and past it
  function automatic in_word_t gen_word();
    in_word_t    w;
    int unsigned nb;
    int unsigned r;
    nb = live_bit_count();
    r  = $urandom_range(99);
    if (r < 40)      w.func = FUNC_WRITE;
    else if (r < 66) w.func = FUNC_READ;
    else if (r < 94) w.func = FUNC_FIND;
    else             w.func = FUNC_FILL;
    w.bit_value = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (nb == 0 || r < 25)
      w.bit_index = 12'($urandom_range(INDEX_LIMIT - 1));
    else if (r < 60)
      w.bit_index = 12'($urandom_range(((nb < 128) ? nb : 128) - 1));
    else if (r < 80)
      w.bit_index = 12'(nb - 1 - $urandom_range(((nb < 64) ? nb : 64) - 1));
    else if (nb < INDEX_LIMIT)
      w.bit_index = 12'($urandom_range(INDEX_LIMIT - 1, nb));
    else
      w.bit_index = 12'($urandom_range(INDEX_LIMIT - 1));
    return w;
  endfunction

  // Present one word, hold it until accepted, then record what it should return.
  // in_valid stays high on return so back-to-back words need no extra edge.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t calc;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = bitmap_apply(w);
    pending_results.push_back(typed ? want : calc);
    words_sent++;
  endtask

  // Stop sending and wait for every outstanding result; optionally let the block settle
  task automatic wait_idle(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_live_bytes(input logic [BYTES_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    live_cfg = v;
    cfg_we   <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_SENDER:   begin send_idle_pct = 56; recv_idle_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_idle_pct = 56; end
      IDLE_BOTH:     begin send_idle_pct = 11; recv_idle_pct = 11; end
      default:       begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endtask

  function automatic logic [BYTES_W-1:0] phase_cfg(int unsigned ph);
    case (ph)
      0:       return 10'd512;
      1:       return 10'd1;
      2:       return 10'd0;
      3:       return 10'd1023;
      4:       return 10'd8;
      5:       return 10'($urandom_range(511, 2));
      6:       return 10'd513;
      7:       return 10'd64;
      8:       return 10'($urandom_range(1023));
      default: return 10'd512;
    endcase
  endfunction

  // Result scoreboard and receiver back-pressure
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.found)       finds_hit++;
      if (out_data.range_error) range_errs++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result word %h", $realtime, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.bit_out !== want.bit_out || out_data.found_index !== want.found_index ||
            out_data.found !== want.found || out_data.range_error !== want.range_error) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: exp bit=%0d idx=%0d found=%0d err=%0d",
                     $realtime, want.bit_out, want.found_index, want.found,
                     want.range_error);
            $display("           got bit=%0d idx=%0d found=%0d err=%0d",
                     out_data.bit_out, out_data.found_index, out_data.found,
                     out_data.range_error);
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    int unsigned pause_at;
    bitmap_img = '0;
    live_cfg   = 10'd512;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset state, index extremes, each op, out-of-range, empty map,
    // saturated register and bytes kept beyond the live range
    add_row(0, 0, FUNC_READ,  12'd0,    1'b0, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_FIND,  12'd0,    1'b1, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_FIND,  12'd4095, 1'b0, 1, result_word(0, 0, 1, 0));
    add_row(0, 0, FUNC_READ,  12'd4095, 1'b1, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_WRITE, 12'd4095, 1'b1, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_FIND,  12'd0,    1'b1, 1, result_word(0, 12'd4095, 1, 0));
    add_row(0, 0, FUNC_WRITE, 12'd0,    1'b1, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_FIND,  12'd0,    1'b1, 1, result_word(0, 0, 1, 0));
    add_row(0, 0, FUNC_FILL,  12'd0,    1'b1, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_FIND,  12'd0,    1'b0, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_READ,  12'd2048, 1'b0, 1, result_word(1, 0, 0, 0));
    add_row(0, 0, FUNC_WRITE, 12'd100,  1'b0, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_FIND,  12'd0,    1'b0, 0, '0);
    add_row(1, 10'd1, FUNC_WRITE, 12'd8, 1'b0, 1, result_word(0, 0, 0, 1));
    add_row(0, 0, FUNC_READ,  12'd8,    1'b0, 1, result_word(0, 0, 0, 1));
    add_row(0, 0, FUNC_READ,  12'd7,    1'b0, 1, result_word(1, 0, 0, 0));
    add_row(0, 0, FUNC_FIND,  12'd0,    1'b0, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_FILL,  12'd0,    1'b0, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_FIND,  12'd0,    1'b1, 1, result_word(0, 0, 0, 0));
    add_row(1, 10'd0, FUNC_WRITE, 12'd0, 1'b1, 1, result_word(0, 0, 0, 1));
    add_row(0, 0, FUNC_READ,  12'd0,    1'b0, 1, result_word(0, 0, 0, 1));
    add_row(0, 0, FUNC_FIND,  12'd0,    1'b0, 1, result_word(0, 0, 0, 0));
    add_row(0, 0, FUNC_FILL,  12'd0,    1'b1, 1, result_word(0, 0, 0, 0));
    add_row(1, 10'd1023, FUNC_READ, 12'd4095, 1'b0, 1, result_word(1, 0, 0, 0));
    add_row(0, 0, FUNC_FIND,  12'd0,    1'b1, 0, '0);

    set_idle(IDLE_NONE);
    foreach (plan[i]) begin
      if (plan[i].set_cfg) begin
        wait_idle(1);
        write_live_bytes(plan[i].cfg);
      end
      send_word(plan[i].word, plan[i].typed, plan[i].want);
    end

    // Random phases, each with its own live size and stall pattern
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle(1);
      write_live_bytes(phase_cfg(ph));
      set_idle(idle_mode_t'(ph % 4));
      pause_at = $urandom_range(WORDS_PER_PHASE - 1);
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        if (k == pause_at) wait_idle(0);
        send_word(gen_word(), 0, '0);
      end
    end

    wait_idle(1);
    $display("sent %0d words over %0d live-size settings in %0d cycles", words_sent,
             PHASES + 4, cycle_count);
    $display("checked %0d results: %0d finds hit, %0d range errors, %0d mismatches",
             results_seen, finds_hit, range_errs, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bff_pkg.sv
design/bff_match.sv
design/bitmap_find_first.sv
design/bff_checker.sv
dv/tb_bitmap_find_first.sv
